[hw/rtl/address_region_table_macros.svh]
// assertion macros used by the address region table controller
`ifndef ADDRESS_REGION_TABLE_MACROS_SVH
`define ADDRESS_REGION_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ART_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ART_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/art_pkg.sv]
// shared types and constants for the address region table
`default_nettype none

package art_pkg;

  localparam int ENTRIES_DEFAULT = 64;
  localparam int FIELD_W = 48;
  localparam int INDEX_W = 6;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd3;

  typedef struct packed {
    logic [FIELD_W-1:0] handle;
    logic [FIELD_W-1:0] shadow;
    logic [FIELD_W-1:0] metadata;
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] size;
  } record_t;

  // which result the datapath captures
  typedef enum logic [2:0] {
    RES_REG_OK,
    RES_REFUSED,
    RES_FULL,
    RES_MISS,
    RES_HIT
  } res_sel_t;

  typedef struct packed {
    logic     accept;
    logic     wr_en;
    logic     scan_run;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic func_lookup;
    logic handle_zero;
    logic addr_zero;
    logic full;
    logic empty;
    logic hit;
    logic scan_end;
  } dp_sts_t;

endpackage

`default_nettype wire

[hw/rtl/art_dp.sv]
// datapath: entry memory, fill count, scan pipeline and result registers
`default_nettype none

module art_dp #(
  parameter int ENTRIES = art_pkg::ENTRIES_DEFAULT
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire  art_pkg::dp_cmd_t            cmd,
  output art_pkg::dp_sts_t                  sts,
  input  wire                               func,
  input  wire  [art_pkg::FIELD_W-1:0]       region_handle,
  input  wire  [art_pkg::FIELD_W-1:0]       shadow_base,
  input  wire  [art_pkg::FIELD_W-1:0]       metadata_base,
  input  wire  [art_pkg::FIELD_W-1:0]       region_base,
  input  wire  [art_pkg::FIELD_W-1:0]       region_size,
  input  wire  [art_pkg::FIELD_W-1:0]       lookup_address,
  output logic [art_pkg::STATUS_W-1:0]      status,
  output logic [art_pkg::INDEX_W-1:0]       entry_index,
  output logic [art_pkg::FIELD_W-1:0]       found_handle,
  output logic [art_pkg::FIELD_W-1:0]       found_shadow,
  output logic [art_pkg::FIELD_W-1:0]       found_metadata,
  output logic [art_pkg::FIELD_W-1:0]       found_base,
  output logic [art_pkg::FIELD_W-1:0]       found_size
);

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(ENTRIES);

  art_pkg::record_t mem [ENTRIES];

  logic [CNTW-1:0]             count;
  logic [CNTW-1:0]             iss;
  logic                        rd_valid;
  logic [IDXW-1:0]             rd_idx;
  art_pkg::record_t            rd_data;
  logic [art_pkg::FIELD_W-1:0] addr_q;
  logic [art_pkg::FIELD_W-1:0] diff;
  logic                        issue;

  logic [art_pkg::STATUS_W-1:0] res_status;
  logic [art_pkg::INDEX_W-1:0]  res_index;
  art_pkg::record_t             res_rec;

  art_pkg::record_t wr_rec;

  assign wr_rec = '{handle:   region_handle,
                    shadow:   shadow_base,
                    metadata: metadata_base,
                    base:     region_base,
                    size:     region_size};

  assign issue = cmd.scan_run && (iss < count);
  assign diff  = addr_q - rd_data.base;

  always_comb begin
    sts.func_lookup = func;
    sts.handle_zero = (region_handle == '0);
    sts.addr_zero   = (lookup_address == '0);
    sts.full        = (count == FULL_COUNT);
    sts.empty       = (count == '0);
    // entries with a zero base never match
    sts.hit         = rd_valid && (rd_data.base != '0) && (addr_q >= rd_data.base) &&
                      (diff < rd_data.size);
    sts.scan_end    = !rd_valid && (iss >= count);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[count[IDXW-1:0]] <= wr_rec;
    end
    if (issue) begin
      rd_data <= mem[iss[IDXW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      iss      <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        count <= count + 1'b1;
      end
      if (cmd.accept) begin
        iss      <= '0;
        rd_valid <= 1'b0;
      end else if (cmd.scan_run) begin
        rd_valid <= issue;
        if (issue) begin
          iss <= iss + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_q <= lookup_address;
    end
    if (issue) begin
      rd_idx <= iss[IDXW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        art_pkg::RES_REG_OK: begin
          res_status <= art_pkg::STATUS_OK;
          res_index  <= art_pkg::INDEX_W'(count[IDXW-1:0]);
          res_rec    <= '0;
        end
        art_pkg::RES_HIT: begin
          res_status <= art_pkg::STATUS_OK;
          res_index  <= art_pkg::INDEX_W'(rd_idx);
          res_rec    <= rd_data;
        end
        art_pkg::RES_FULL: begin
          res_status <= art_pkg::STATUS_FULL;
          res_index  <= '0;
          res_rec    <= '0;
        end
        art_pkg::RES_MISS: begin
          res_status <= art_pkg::STATUS_MISS;
          res_index  <= '0;
          res_rec    <= '0;
        end
        default: begin
          res_status <= art_pkg::STATUS_REFUSED;
          res_index  <= '0;
          res_rec    <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status         <= res_status;
      entry_index    <= res_index;
      found_handle   <= res_rec.handle;
      found_shadow   <= res_rec.shadow;
      found_metadata <= res_rec.metadata;
      found_base     <= res_rec.base;
      found_size     <= res_rec.size;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/art_ctrl.sv]
// controller: request sequencing, scan control and output handshake
`default_nettype none

`include "address_region_table_macros.svh"

module art_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire                   out_stall,
  input  wire art_pkg::dp_sts_t sts,
  output art_pkg::dp_cmd_t      cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    REPORT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    cmd.res_sel = art_pkg::RES_REFUSED;
    state_next = state;
    case (state)
      IDLE: begin
        cmd.accept = in_valid && !in_stall;
        if (cmd.accept) begin
          cmd.res_load = 1'b1;
          state_next   = REPORT;
          if (!sts.func_lookup) begin
            if (sts.handle_zero) begin
              cmd.res_sel = art_pkg::RES_REFUSED;
            end else if (sts.full) begin
              cmd.res_sel = art_pkg::RES_FULL;
            end else begin
              cmd.res_sel = art_pkg::RES_REG_OK;
              cmd.wr_en   = 1'b1;
            end
          end else if (sts.addr_zero) begin
            cmd.res_sel = art_pkg::RES_REFUSED;
          end else if (sts.empty) begin
            cmd.res_sel = art_pkg::RES_MISS;
          end else begin
            cmd.res_load = 1'b0;
            state_next   = SCAN;
          end
        end
      end
      SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = art_pkg::RES_HIT;
          state_next   = REPORT;
        end else if (sts.scan_end) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = art_pkg::RES_MISS;
          state_next   = REPORT;
        end
      end
      REPORT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != IDLE);
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ART_ASSERT_IMP(a_out_load_free, clk, rst, cmd.out_load, out_free, "result overwrites a pending one")
  `ART_ASSERT_NXT(a_busy_after_req, clk, rst, cmd.accept, in_stall, "request taken while busy")
  `ART_ASSERT_IMP(a_hit_not_end, clk, rst, sts.hit, !sts.scan_end, "hit and scan end together")
  `ART_ASSERT_IMP(a_rose_from_load, clk, rst, $rose(out_valid), $past(cmd.out_load), "output valid without load")

endmodule

`default_nettype wire

[hw/rtl/address_region_table.sv]
// Address region table. A register request (func 0) appends a region record at the next free
// entry; a lookup request (func 1) returns the first filled entry with a nonzero base whose range
// base <= address < base + size. Both channels use valid/stall. A register request, a refusal or
// a lookup on an empty table loads the result register on acceptance, and the output register
// in REPORT once the output is free; a lookup that scans reads the filled entries in order in
// SCAN, one entry per cycle from the single read port of the entry memory, and stops at the
// first hit. Input stall drops at the edge that loads the output register, so no new request
// is taken until the last result has reached the output register; a held output stall keeps
// the result waiting and holds off the next request. One request is in work at a time; a
// finished result waits in the output register while the next request is taken. Reset empties
// the table at once (no clearing pass).
`default_nettype none

module address_region_table #(
  parameter int ENTRIES = art_pkg::ENTRIES_DEFAULT
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          func,
  input  wire  [art_pkg::FIELD_W-1:0]  region_handle,
  input  wire  [art_pkg::FIELD_W-1:0]  shadow_base,
  input  wire  [art_pkg::FIELD_W-1:0]  metadata_base,
  input  wire  [art_pkg::FIELD_W-1:0]  region_base,
  input  wire  [art_pkg::FIELD_W-1:0]  region_size,
  input  wire  [art_pkg::FIELD_W-1:0]  lookup_address,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [art_pkg::STATUS_W-1:0] status,
  output logic [art_pkg::INDEX_W-1:0]  entry_index,
  output logic [art_pkg::FIELD_W-1:0]  found_handle,
  output logic [art_pkg::FIELD_W-1:0]  found_shadow,
  output logic [art_pkg::FIELD_W-1:0]  found_metadata,
  output logic [art_pkg::FIELD_W-1:0]  found_base,
  output logic [art_pkg::FIELD_W-1:0]  found_size
);

  art_pkg::dp_cmd_t cmd;
  art_pkg::dp_sts_t sts;

  art_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  art_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .func           (func),
    .region_handle  (region_handle),
    .shadow_base    (shadow_base),
    .metadata_base  (metadata_base),
    .region_base    (region_base),
    .region_size    (region_size),
    .lookup_address (lookup_address),
    .status         (status),
    .entry_index    (entry_index),
    .found_handle   (found_handle),
    .found_shadow   (found_shadow),
    .found_metadata (found_metadata),
    .found_base     (found_base),
    .found_size     (found_size)
  );

endmodule

`default_nettype wire

[test/address_region_table_tb.sv]
// testbench for the address region table: random register and lookup requests with a scoreboard
`timescale 1ns / 100ps

module address_region_table_tb;

  localparam int ENTRIES = art_pkg::ENTRIES_DEFAULT;
  localparam int W = art_pkg::FIELD_W;
  localparam logic FUNC_REGISTER = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;
  localparam int RANDOM_REQUESTS = 450;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic         func;
    logic [W-1:0] handle;
    logic [W-1:0] shadow;
    logic [W-1:0] metadata;
    logic [W-1:0] base;
    logic [W-1:0] size;
    logic [W-1:0] addr;
  } region_req_t;

  typedef struct packed {
    logic [art_pkg::STATUS_W-1:0] status;
    logic [art_pkg::INDEX_W-1:0]  index;
    logic [W-1:0]                 handle;
    logic [W-1:0]                 shadow;
    logic [W-1:0]                 metadata;
    logic [W-1:0]                 base;
    logic [W-1:0]                 size;
  } region_result_t;

  class region_table_scoreboard;
    logic [W-1:0] handle_tab [ENTRIES];
    logic [W-1:0] shadow_tab [ENTRIES];
    logic [W-1:0] metadata_tab [ENTRIES];
    logic [W-1:0] base_tab [ENTRIES];
    logic [W-1:0] size_tab [ENTRIES];
    int filled;
    int mismatches;
    region_result_t pending_results[$];

    function new();
      filled = 0;
      mismatches = 0;
    endfunction

    // append or resolve, and queue the result the table must give
    function void accept_request(region_req_t req);
      region_result_t res;
      logic [W-1:0] offset;
      bit hit;
      res = '0;
      hit = 1'b0;
      if (req.func == FUNC_REGISTER) begin
        if (req.handle == '0) begin
          res.status = art_pkg::STATUS_REFUSED;
        end else if (filled >= ENTRIES) begin
          res.status = art_pkg::STATUS_FULL;
        end else begin
          handle_tab[filled] = req.handle;
          shadow_tab[filled] = req.shadow;
          metadata_tab[filled] = req.metadata;
          base_tab[filled] = req.base;
          size_tab[filled] = req.size;
          res.status = art_pkg::STATUS_OK;
          res.index = art_pkg::INDEX_W'(filled);
          filled++;
        end
      end else if (req.addr == '0) begin
        res.status = art_pkg::STATUS_REFUSED;
      end else begin
        res.status = art_pkg::STATUS_MISS;
        // first filled entry wins; a zero base never matches
        for (int i = 0; i < filled && !hit; i++) begin
          if (base_tab[i] != '0 && req.addr >= base_tab[i]) begin
            offset = req.addr - base_tab[i];
            if (offset < size_tab[i]) begin
              hit = 1'b1;
              res.status = art_pkg::STATUS_OK;
              res.index = art_pkg::INDEX_W'(i);
              res.handle = handle_tab[i];
              res.shadow = shadow_tab[i];
              res.metadata = metadata_tab[i];
              res.base = base_tab[i];
              res.size = size_tab[i];
            end
          end
        end
      end
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [W-1:0] want, logic [W-1:0] got);
      if (got !== want) begin
        $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(region_result_t got);
      region_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", W'(want.status), W'(got.status));
      compare_field("entry_index", W'(want.index), W'(got.index));
      compare_field("found_handle", want.handle, got.handle);
      compare_field("found_shadow", want.shadow, got.shadow);
      compare_field("found_metadata", want.metadata, got.metadata);
      compare_field("found_base", want.base, got.base);
      compare_field("found_size", want.size, got.size);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic func;
  logic [W-1:0] region_handle;
  logic [W-1:0] shadow_base;
  logic [W-1:0] metadata_base;
  logic [W-1:0] region_base;
  logic [W-1:0] region_size;
  logic [W-1:0] lookup_address;
  logic out_valid;
  logic out_stall;
  logic [art_pkg::STATUS_W-1:0] status;
  logic [art_pkg::INDEX_W-1:0] entry_index;
  logic [W-1:0] found_handle;
  logic [W-1:0] found_shadow;
  logic [W-1:0] found_metadata;
  logic [W-1:0] found_base;
  logic [W-1:0] found_size;

  region_table_scoreboard sb;
  int results_seen;

  address_region_table uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .region_handle(region_handle),
    .shadow_base(shadow_base),
    .metadata_base(metadata_base),
    .region_base(region_base),
    .region_size(region_size),
    .lookup_address(lookup_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .entry_index(entry_index),
    .found_handle(found_handle),
    .found_shadow(found_shadow),
    .found_metadata(found_metadata),
    .found_base(found_base),
    .found_size(found_size)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[W-1:0];
  endfunction

  function automatic region_req_t register_req(logic [W-1:0] handle, logic [W-1:0] base,
                                               logic [W-1:0] size);
    region_req_t req;
    req.func = FUNC_REGISTER;
    req.handle = handle;
    req.shadow = rand48();
    req.metadata = rand48();
    req.base = base;
    req.size = size;
    req.addr = rand48();
    return req;
  endfunction

  function automatic region_req_t lookup_req(logic [W-1:0] addr);
    region_req_t req;
    req = register_req(rand48(), rand48(), rand48());
    req.func = FUNC_LOOKUP;
    req.addr = addr;
    return req;
  endfunction

  function automatic region_req_t random_request();
    region_req_t req;
    int unsigned r;
    int j;
    logic [W-1:0] b;
    logic [W-1:0] s;
    req = lookup_req(rand48());
    r = $urandom_range(0, 99);
    if (r < 35) begin
      req.func = FUNC_REGISTER;
      if ($urandom_range(0, 19) == 0) req.handle = '0;
      r = $urandom_range(0, 99);
      if (r < 6) req.base = '0;
      else if (r < 25 && sb.filled > 0)
        // overlap an existing region so that order decides the hit
        req.base = sb.base_tab[$urandom_range(0, sb.filled - 1)] + W'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 10) req.size = '0;
      else if (r < 50) req.size = W'($urandom_range(1, 4096));
      else if (r < 80) req.size = rand48() >> $urandom_range(8, 40);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        req.addr = '0;
      end else if (r < 80 && sb.filled > 0) begin
        j = $urandom_range(0, sb.filled - 1);
        b = sb.base_tab[j];
        s = sb.size_tab[j];
        case ($urandom_range(0, 4))
          0, 1: req.addr = b + ((s != '0) ? rand48() % s : '0);
          2: req.addr = b + s - W'(1);
          3: req.addr = b + s;
          default: req.addr = b - W'(1);
        endcase
      end
    end
    return req;
  endfunction

  // mostly back to back, some short gaps, a few long ones, and stretches with no gaps at all
  function automatic int sender_gap(int n);
    int unsigned r;
    if ((n / 40) % 4 == 3) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // entered and left at a falling edge
  task automatic send_request(input region_req_t req);
    in_valid <= 1'b1;
    func <= req.func;
    region_handle <= req.handle;
    shadow_base <= req.shadow;
    metadata_base <= req.metadata;
    region_base <= req.base;
    region_size <= req.size;
    lookup_address <= req.addr;
    do @(posedge clk); while (in_stall);
    sb.accept_request(req);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(region_result_t'({status, entry_index, found_handle, found_shadow,
                                        found_metadata, found_base, found_size}));
      results_seen++;
    end
  end

  initial begin : result_drain
    int stall_left;
    int cyc;
    int unsigned r;
    bit held;
    stall_left = 0;
    cyc = 0;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      // one long hold so the table backs up and stalls its input
      if (!held && results_seen >= 120) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ((cyc / 600) % 3 != 2) begin
          r = $urandom_range(0, 99);
          if (r < 15) stall_left = $urandom_range(1, 3);
          else if (r < 18) stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin
    region_req_t directed[$];
    logic [W-1:0] ones;
    ones = '1;
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_REGISTER;
    region_handle = '0;
    shadow_base = '0;
    metadata_base = '0;
    region_base = '0;
    region_size = '0;
    lookup_address = '0;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed.push_back(lookup_req(48'h1));
    directed.push_back(lookup_req('0));
    directed.push_back(register_req('0, ones, ones));
    directed.push_back(register_req(ones, ones, ones));
    directed[3].shadow = ones;
    directed[3].metadata = ones;
    directed.push_back(register_req(48'h1, '0, ones));
    directed.push_back(register_req(48'h2, 48'h1000, '0));
    directed.push_back(register_req(48'h3, 48'h1000, 48'h100));
    directed.push_back(register_req(48'h4, 48'h1000, 48'h2000));
    directed.push_back(register_req(48'h5, 48'h1, 48'h1));
    directed[8].shadow = '0;
    directed[8].metadata = '0;
    directed.push_back(lookup_req(48'h1000));
    directed.push_back(lookup_req(48'h10ff));
    directed.push_back(lookup_req(48'h1100));
    directed.push_back(lookup_req(48'h2fff));
    directed.push_back(lookup_req(48'h3000));
    directed.push_back(lookup_req(48'hfff));
    directed.push_back(lookup_req(48'h1));
    directed.push_back(lookup_req(48'h2));
    directed.push_back(lookup_req(ones));
    directed.push_back(lookup_req(ones - W'(1)));
    directed.push_back(lookup_req('0));
    foreach (directed[k]) begin
      send_request(directed[k]);
      idle_sender(sender_gap(k));
    end
    wait_for_results();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 2) wait_for_results();
      send_request(random_request());
      idle_sender(sender_gap(n));
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
